// ===== rtl/spl_pkg.sv =====
`timescale 1ns / 1ps
package spl_pkg;
  localparam int Levels = 64;
  localparam int CountW = $clog2(Levels + 1);

  localparam logic [2:0] StIncreased = 3'd0;
  localparam logic [2:0] StInserted  = 3'd1;
  localparam logic [2:0] StReduced   = 3'd2;
  localparam logic [2:0] StRemoved   = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;
  localparam logic [2:0] StAbsent    = 3'd5;

  typedef struct packed {
    logic               mode;
    logic               is_bid;
    logic signed [31:0] price;
    logic [30:0]        shares;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        level_shares;
    logic signed [31:0] best_price;
    logic [31:0]        best_shares;
    logic               side_empty;
  } out_beat_t;

  // Broadcast command to every cell of one side.
  typedef struct packed {
    logic               act;      // apply an update this cycle
    logic               reduce;
    logic               is_bid;
    logic signed [31:0] price;
    logic [30:0]        shares;
    logic               allow_ins; // insert permitted if price absent
  } cell_cmd_t;

  // Per-cell status seen by its neighbors and the collector.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] price;
    logic [31:0]        shares;
  } cell_view_t;
endpackage

// ===== rtl/spl_cell.sv =====
`timescale 1ns / 1ps
module spl_cell (
  input  logic                clk,
  input  logic                rst,
  input  spl_pkg::cell_cmd_t  cmd,
  input  logic                match_any,  // some cell on this side holds price
  input  spl_pkg::cell_view_t prev_view,  // cell toward the best end
  input  logic                prev_ahead, // prev cell: new price goes ahead of it
  input  logic                prev_gone,  // prev cell or earlier is being removed
  input  spl_pkg::cell_view_t next_view,  // cell toward the worse end
  output spl_pkg::cell_view_t view,
  output logic                ahead,
  output logic                match,
  output logic                gone
);
  import spl_pkg::*;

  logic               valid;
  logic signed [31:0] price;
  logic [31:0]        shares;
  logic [32:0]        sum;
  logic               remove_here;
  logic               ins;

  assign view  = '{valid: valid, price: price, shares: shares};
  assign match = valid && (price == cmd.price);
  // new price goes ahead of this entry; empty entries count as ahead
  assign ahead = !valid || (cmd.is_bid ? (cmd.price > price) : (cmd.price < price));
  assign sum   = {1'b0, shares} + {2'b0, cmd.shares};
  assign remove_here = match && cmd.reduce && (shares <= {1'b0, cmd.shares});
  assign gone  = prev_gone || remove_here;
  assign ins   = cmd.act && !cmd.reduce && !match_any && cmd.allow_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (ahead) valid <= prev_view.valid || !prev_ahead || valid;
    end else if (cmd.act && cmd.reduce && gone) begin
      valid <= next_view.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      if (cmd.reduce) begin
        if (prev_gone) begin
          price  <= next_view.price;
          shares <= next_view.shares;
        end else if (remove_here) begin
          price  <= next_view.price;
          shares <= next_view.shares;
        end else if (match) begin
          shares <= shares - {1'b0, cmd.shares};
        end
      end else if (match) begin
        shares <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else if (ins && ahead) begin
        if (prev_ahead) begin
          // shift one place toward the worse end
          price  <= prev_view.price;
          shares <= prev_view.shares;
        end else begin
          price  <= cmd.price;
          shares <= {1'b0, cmd.shares};
        end
      end
    end
  end
endmodule

// ===== rtl/spl_side.sv =====
`timescale 1ns / 1ps
module spl_side (
  input  logic                clk,
  input  logic                rst,
  input  spl_pkg::cell_cmd_t  cmd,
  output logic                found,
  output logic                side_full,
  output logic [31:0]         hit_shares,
  output spl_pkg::cell_view_t top
);
  import spl_pkg::*;

  cell_view_t             views [Levels];
  logic [Levels-1:0]      aheads, hit_bits, gones;
  logic [Levels-1:0][31:0] hit_terms;

  assign found     = |hit_bits;
  assign side_full = views[Levels-1].valid;
  assign top       = views[0];

  for (genvar g = 0; g < Levels; g++) begin : g_cell
    cell_view_t pv, nv;
    logic       pa, pg;
    if (g == 0) begin : g_first
      assign pv = '0;
      assign pa = 1'b0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = views[g-1];
      assign pa = aheads[g-1];
      assign pg = gones[g-1];
    end
    if (g == Levels - 1) begin : g_last
      assign nv = '0;
    end else begin : g_inner
      assign nv = views[g+1];
    end
    spl_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .match_any(found),
      .prev_view(pv), .prev_ahead(pa), .prev_gone(pg), .next_view(nv),
      .view(views[g]), .ahead(aheads[g]), .match(hit_bits[g]), .gone(gones[g])
    );
    assign hit_terms[g] = hit_bits[g] ? views[g].shares : 32'd0;
  end

  always_comb begin
    hit_shares = '0;
    for (int i = 0; i < Levels; i++) hit_shares |= hit_terms[i];
  end
endmodule

// ===== rtl/sorted_price_level_book.sv =====
`timescale 1ns / 1ps
// Two-sided price-level book. Each input beat on in_beat (in_valid/in_stall)
// adds or reduces shares at a price on the bid or ask side. Each side is a
// chain of 64 cells kept sorted, best price at cell 0; an insert shifts the
// cells behind the new price one place back, a removal pulls them forward,
// all in the same update. Both sides share a pool of 64 levels.
// Every input beat yields one output beat on out_beat (out_valid/out_stall)
// with the status, the touched level's shares and the best level of the side.
// The input is captured into item, then in SLook the cell chain is updated and
// the status and touched level's shares are registered, then in SShow the best
// level is captured and out_valid is raised.
// A new input is not taken until these steps for the last one have run one
// after another; in_stall stays high meanwhile.
// A result held by out_stall blocks the next update; the next input waits in
// its capture register until the output register frees.
// Reset (rst, synchronous) empties both sides and the pool count.
module sorted_price_level_book (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spl_pkg::in_beat_t    in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spl_pkg::out_beat_t   out_beat
);
  import spl_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLook = 2'd1;
  localparam logic [1:0] SShow = 2'd2;

  logic [1:0]        state;
  in_beat_t          item;
  logic [CountW-1:0] levels_in_use;
  logic [2:0]        status;
  logic [31:0]       lvl;
  cell_cmd_t         cmd_bid, cmd_ask;
  logic              found_b, found_a, full_b, full_a, found, side_full;
  logic [31:0]       hit_b, hit_a, hit, sum_sat;
  logic [32:0]       sum;
  cell_view_t        top_b, top_a, top;
  logic              apply, allow;

  assign in_stall = (state != SIdle);
  assign apply    = (state == SLook) && (!out_valid || !out_stall);
  assign allow    = (levels_in_use < CountW'(Levels));

  always_comb begin
    cmd_bid = '{act: apply && item.is_bid, reduce: item.mode, is_bid: 1'b1,
                price: item.price, shares: item.shares, allow_ins: allow};
    cmd_ask = cmd_bid;
    cmd_ask.act    = apply && !item.is_bid;
    cmd_ask.is_bid = 1'b0;
  end

  spl_side u_bid (.clk(clk), .rst(rst), .cmd(cmd_bid), .found(found_b),
                  .side_full(full_b), .hit_shares(hit_b), .top(top_b));
  spl_side u_ask (.clk(clk), .rst(rst), .cmd(cmd_ask), .found(found_a),
                  .side_full(full_a), .hit_shares(hit_a), .top(top_a));

  assign found     = item.is_bid ? found_b : found_a;
  assign side_full = item.is_bid ? full_b : full_a;
  assign hit       = item.is_bid ? hit_b : hit_a;
  assign top       = item.is_bid ? top_b : top_a;
  assign sum       = {1'b0, hit} + {2'b0, item.shares};
  assign sum_sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    status = StAbsent;
    lvl    = '0;
    if (!item.mode) begin
      if (found) begin
        status = StIncreased;
        lvl    = sum_sat;
      end else if (!allow || side_full) begin
        status = StFull;
      end else begin
        status = StInserted;
        lvl    = {1'b0, item.shares};
      end
    end else if (found) begin
      if (hit > {1'b0, item.shares}) begin
        status = StReduced;
        lvl    = hit - {1'b0, item.shares};
      end else begin
        status = StRemoved;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= SIdle;
      out_valid     <= 1'b0;
      levels_in_use <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        SIdle: if (in_valid) state <= SLook;
        SLook: if (apply) begin
          state <= SShow;
          if (status == StInserted) levels_in_use <= levels_in_use + 1'b1;
          if (status == StRemoved && levels_in_use != '0)
            levels_in_use <= levels_in_use - 1'b1;
        end
        SShow: begin
          state     <= SIdle;
          out_valid <= 1'b1;
        end
        default: state <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == SIdle && in_valid) item <= in_beat;
    if (apply) begin
      out_beat.status       <= status;
      out_beat.level_shares <= lvl;
    end
    // best level after the chain update
    if (state == SShow) begin
      out_beat.side_empty  <= !top.valid;
      out_beat.best_price  <= top.valid ? top.price : 32'sd0;
      out_beat.best_shares <= top.valid ? top.shares : 32'd0;
    end
  end
endmodule
